@@ rtl/core/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Operation codes and sequencer state type for the range sortable array.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SORT  = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_RADDR = 8'b0000_0100,
    ST_DONE  = 8'b0000_1000,
    ST_SI    = 8'b0001_0000,
    ST_SV    = 8'b0010_0000,
    ST_SP    = 8'b0100_0000,
    ST_SC    = 8'b1000_0000
  } state_t;

endpackage

@@ rtl/core/range_sortable_array.sv @@
// ----------------------------------------------------------------------------
// range_sortable_array
// Element store with read, write and in-place range sort of a span.
// ----------------------------------------------------------------------------
// Usage: pulse start with in_* valid while busy is low; the transaction is
// taken on that edge and busy rises until the result is delivered. Each
// transaction yields one result, shown for one cycle with out_strobe high.
// A write, a short span, a bad index, a bad span and the unused opcode show
// their result in the cycle right after the accepting edge; a read first
// passes through ST_RADDR for the memory read. A sort of n elements runs an
// insertion sort on one single-port-read, single-write memory with one shared
// key comparator: each element passes ST_SI and ST_SV, then ST_SP and ST_SC
// in turn until its place is found; the registered memory read sets the step
// length. Busy falls in the cycle after the strobe.
// After reset the block clears every entry of the store, one entry a cycle,
// with busy high. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module range_sortable_array #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_index,
  input  logic [31:0] in_new_value,
  input  logic [8:0]  in_range_low,
  input  logic [8:0]  in_range_high,
  input  logic        in_descending,
  output logic        out_strobe,
  output logic [31:0] out_read_value,
  output logic        out_status
);
  import rsa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  logic desc_r, desc_nxt, st_r, st_nxt, rd_op_r, rd_op_nxt;
  logic [KEY_WIDTH-1:0] v_r, v_nxt, rdata_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic wr_en, accept, idx_ok, span_bad, after;
  logic [CW-1:0] jm1;

  assign accept   = start && (state_r == ST_IDLE);
  assign idx_ok   = 32'(in_index) < DEPTH_W;
  assign span_bad = (in_range_low > in_range_high) || (32'(in_range_high) > DEPTH_W);
  assign jm1      = j_r - CW'(1);
  // Single shared comparator: does the fetched key belong after v?
  assign after    = desc_r ? (rdata_r < v_r) : (rdata_r > v_r);

  always_comb begin
    case (state_r)
      ST_SI:   rd_addr = i_r[AW-1:0];
      ST_SP:   rd_addr = jm1[AW-1:0];
      default: rd_addr = idx_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    desc_nxt  = desc_r;
    st_nxt    = st_r;
    rd_op_nxt = rd_op_r;
    v_nxt     = v_r;
    wr_en     = 1'b0;
    wr_addr   = j_r[AW-1:0];
    wr_data   = v_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == DEPTH_W - 32'd1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = AW'(in_index);
          lo_nxt    = CW'(in_range_low);
          hi_nxt    = CW'(in_range_high);
          desc_nxt  = in_descending;
          rd_op_nxt = 1'b0;
          st_nxt    = 1'b0;
          state_nxt = ST_DONE;
          case (in_mode)
            OP_READ: begin
              if (idx_ok) begin
                rd_op_nxt = 1'b1;
                state_nxt = ST_RADDR;
              end else begin
                st_nxt = 1'b1;
              end
            end
            OP_WRITE: begin
              if (idx_ok) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_index);
                wr_data = KEY_WIDTH'(in_new_value);
              end else begin
                st_nxt = 1'b1;
              end
            end
            OP_SORT: begin
              if (span_bad) begin
                st_nxt = 1'b1;
              end else if (in_range_high - in_range_low > 9'd1) begin
                i_nxt     = CW'(in_range_low) + CW'(1);
                state_nxt = ST_SI;
              end
            end
            default: st_nxt = 1'b1;
          endcase
        end
      end
      ST_RADDR: state_nxt = ST_DONE;
      ST_SI: begin
        state_nxt = (i_r >= hi_r) ? ST_DONE : ST_SV;
      end
      ST_SV: begin
        v_nxt     = rdata_r;
        j_nxt     = i_r;
        state_nxt = ST_SP;
      end
      ST_SP: begin
        if (j_r == lo_r) begin
          wr_en     = 1'b1;
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_SI;
        end else begin
          state_nxt = ST_SC;
        end
      end
      ST_SC: begin
        wr_en = 1'b1;
        if (after) begin
          wr_data   = rdata_r;
          j_nxt     = jm1;
          state_nxt = ST_SP;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_SI;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    desc_r  <= desc_nxt;
    st_r    <= st_nxt;
    rd_op_r <= rd_op_nxt;
    v_r     <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = (state_r == ST_DONE);
  assign out_status     = st_r;
  assign out_read_value = rd_op_r ? 32'(rdata_r) : 32'd0;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy did not rise after a transaction");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy) else $error("block not idle after result");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (out_read_value == 32'd0))
    else $error("error result carries data");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Range sortable array testbench
// Drives read, write, range sort and unused-opcode transactions through the command port
// and checks every result against an in-bench model of the element store.
// ----------------------------------------------------------------------------
module testbench;
  import rsa_pkg::*;

  localparam int DEPTH     = 256;
  localparam int WDOG_MAX  = 400000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  index;
    logic [31:0] new_value;
    logic [8:0]  range_low;
    logic [8:0]  range_high;
    logic        descending;
  } op_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [7:0]  in_index;
  logic [31:0] in_new_value;
  logic [8:0]  in_range_low;
  logic [8:0]  in_range_high;
  logic        in_descending;
  logic        out_strobe;
  logic [31:0] out_read_value;
  logic        out_status;

  op_t   pending_ops[$];
  res_t  expected_results[$];
  logic [31:0] shadow_store[DEPTH];
  int    mismatches;
  int    idle_pct;
  int    watchdog;
  bit    stim_done;

  range_sortable_array DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_index(in_index), .in_new_value(in_new_value),
    .in_range_low(in_range_low), .in_range_high(in_range_high),
    .in_descending(in_descending), .out_strobe(out_strobe),
    .out_read_value(out_read_value), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Insertion sort, stable, over the half-open span.
  function automatic void sort_shadow(input int lo, input int hi, input bit desc);
    logic [31:0] v;
    int j;
    for (int i = lo + 1; i < hi; i++) begin
      v = shadow_store[i];
      j = i;
      while (j > lo && (desc ? (shadow_store[j-1] < v) : (shadow_store[j-1] > v))) begin
        shadow_store[j] = shadow_store[j-1];
        j--;
      end
      shadow_store[j] = v;
    end
  endfunction

  function automatic res_t apply_op(input op_t op);
    res_t r;
    r = '0;
    case (op.mode)
      OP_READ: r.read_value = shadow_store[op.index];
      OP_WRITE: shadow_store[op.index] = op.new_value;
      OP_SORT: begin
        if (op.range_low > op.range_high || op.range_high > DEPTH) r.status = 1'b1;
        else if (op.range_high - op.range_low > 1)
          sort_shadow(op.range_low, op.range_high, op.descending);
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  function automatic op_t make_op(input logic [1:0] m, input logic [7:0] idx,
                                  input logic [31:0] val, input logic [8:0] lo,
                                  input logic [8:0] hi, input logic desc);
    op_t op;
    op.mode = m; op.index = idx; op.new_value = val;
    op.range_low = lo; op.range_high = hi; op.descending = desc;
    return op;
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t rand_op();
    int lo, hi, w;
    logic [1:0] m;
    m = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) < 5) begin
      // Mostly narrow spans keep sort time short; a few are wide.
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 256) : $urandom_range(0, 24);
      lo = $urandom_range(0, 256 - w);
      hi = lo + w;
    end else if ($urandom_range(0, 1)) begin
      lo = $urandom_range(0, 511);
      hi = $urandom_range(0, 511);
    end else begin
      hi = $urandom_range(0, 256);
      lo = $urandom_range(0, 256);
    end
    if (m == OP_WRITE && $urandom_range(0, 1) == 0) m = OP_WRITE;
    return make_op(m, 8'($urandom), rand_key(), 9'(lo), 9'(hi), 1'($urandom));
  endfunction

  initial begin
    // Directed part: extremes, every operation and each special case.
    pending_ops.push_back(make_op(OP_READ, 8'd0, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_READ, 8'd255, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_WRITE, 8'd0, 32'hFFFF_FFFF, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_WRITE, 8'd255, 32'h0000_0001, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_WRITE, 8'd1, 32'h8000_0000, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_WRITE, 8'd2, 32'h5555_AAAA, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_READ, 8'd0, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'd0, 32'h0, 9'd0, 9'd4, 1'b0));
    pending_ops.push_back(make_op(OP_READ, 8'd3, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'd0, 32'h0, 9'd0, 9'd4, 1'b1));
    pending_ops.push_back(make_op(OP_READ, 8'd0, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'd0, 32'h0, 9'd0, 9'd256, 1'b1));
    pending_ops.push_back(make_op(OP_READ, 8'd1, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'd0, 32'h0, 9'd0, 9'd256, 1'b0));
    pending_ops.push_back(make_op(OP_READ, 8'd255, 32'h0, 9'd0, 9'd0, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'hFF, 32'h0, 9'd5, 9'd4, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'h0, 32'h0, 9'd0, 9'd257, 1'b1));
    pending_ops.push_back(make_op(OP_SORT, 8'h0, 32'h0, 9'd511, 9'd511, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'h0, 32'h0, 9'd256, 9'd256, 1'b0));
    pending_ops.push_back(make_op(OP_SORT, 8'h0, 32'h0, 9'd255, 9'd256, 1'b1));
    pending_ops.push_back(make_op(2'd3, 8'hFF, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF, 1'b1));
    pending_ops.push_back(make_op(2'd3, 8'h00, 32'h0, 9'd0, 9'd0, 1'b0));
    for (int i = 0; i < 268; i++) pending_ops.push_back(rand_op());
  end

  // Idling schedule follows the count of accepted transactions.
  int accepted;
  always_comb begin
    if (accepted < 100) idle_pct = 32;
    else if (accepted < 200) idle_pct = 52;
    else idle_pct = 0;
  end

  always @(negedge clk) begin
    if (!rst_n || pending_ops.size() == 0) begin
      start <= 1'b0;
    end else if (!(start && !busy) || 1) begin
      if (!busy && $urandom_range(0, 99) >= idle_pct) begin
        start         <= 1'b1;
        in_mode       <= pending_ops[0].mode;
        in_index      <= pending_ops[0].index;
        in_new_value  <= pending_ops[0].new_value;
        in_range_low  <= pending_ops[0].range_low;
        in_range_high <= pending_ops[0].range_high;
        in_descending <= pending_ops[0].descending;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (start && !busy) begin
        want = apply_op(pending_ops.pop_front());
        expected_results.push_back(want);
        accepted <= accepted + 1;
      end
      if (out_strobe) begin
        got.read_value = out_read_value;
        got.status = out_status;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: read_value %h status %b",
                                         got.read_value, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: read_value exp %h got %h, status exp %b got %b",
                       want.read_value, got.read_value, want.status, got.status);
          end
        end
      end
    end
  end

  initial begin
    start = 1'b0; in_mode = '0; in_index = '0; in_new_value = '0;
    in_range_low = '0; in_range_high = '0; in_descending = 1'b0;
    mismatches = 0; watchdog = 0; accepted = 0; stim_done = 1'b0;
    for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    fork
      begin
        wait (pending_ops.size() == 0 && expected_results.size() == 0);
        repeat (20) @(posedge clk);
        stim_done = 1'b1;
      end
      begin
        wait (watchdog >= WDOG_MAX);
      end
    join_any
    if (stim_done && mismatches == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rsa_pkg.sv
rtl/core/range_sortable_array.sv
dv/testbench.sv
